/* rtl/sarp_pkg.sv */
// Package for the sync-and-ramp pulse train generator.
// Holds payload structs, phase enum, register indexes and reset values.
// No dependencies.
package sarp_pkg;

  localparam int TIME_BITS  = 16;
  localparam int INDEX_BITS = 5;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int BASE_W      = 16;
  localparam int GAP_W       = 16;
  localparam int COUNT_W     = 5;
  localparam int FGAP_W      = 16;
  localparam int SYNC_W      = 10;
  localparam int STEP_W      = 10;

  localparam logic [BASE_W-1:0]  BASE_RST  = BASE_W'(13 * 100);
  localparam logic [GAP_W-1:0]   GAP_RST   = GAP_W'(1 * 100);
  localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(3 + 4);
  localparam logic [FGAP_W-1:0]  FGAP_RST  = FGAP_W'(4 * 500);
  localparam logic [SYNC_W-1:0]  SYNC_RST  = SYNC_W'(50);
  localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_WIDTH  = 3'd0,
    REG_GAP_WIDTH   = 3'd1,
    REG_PULSE_COUNT = 3'd2,
    REG_FRAME_GAP   = 3'd3,
    REG_SYNC_WIDTH  = 3'd4,
    REG_WIDTH_STEP  = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_BOUNDARY = 3'd0,
    PH_SYNC     = 3'd1,
    PH_DATA     = 3'd2,
    PH_GAP      = 3'd3,
    PH_FGAP     = 3'd4
  } phase_t;

  typedef struct packed {
    logic enable_press;
    logic select_press;
  } in_item_t;

  typedef struct packed {
    logic sync_level;
    logic data_level;
    logic mode_now;
  } out_item_t;

endpackage

/* rtl/sync_and_ramp_pulse_train_generator.sv */
// Top level of the sync-and-ramp pulse train generator.
// Frame sequencer, config registers and result register; uses sarp_pkg.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_stall   | sarp_pkg::in_item_t (press flags)
//  out_    | output    | out_valid/out_stall | sarp_pkg::out_item_t (pin levels, mode)
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index (3b), cfg_data (16b)
//
// One tick per cycle while in_stall is low: a request is taken every such clock and
// its levels are loaded into the result register at the accepting edge, so the
// result is offered in the next cycle. The path is one 5x10 multiply, an add and
// a compare for the phase length. in_stall is high only while a result waits and
// out_stall holds it. Synchronous active-low reset puts the sequencer at a frame
// boundary with output enabled, ascending mode and default registers.
module sync_and_ramp_pulse_train_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sarp_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sarp_pkg::out_item_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sarp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sarp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sarp_pkg::*;

  localparam int PROD_W = INDEX_BITS + STEP_W;
  localparam int MAX_A  = (PROD_W > BASE_W) ? PROD_W : BASE_W;
  localparam int MAX_B  = (MAX_A > TIME_BITS) ? MAX_A : TIME_BITS;
  localparam int SUM_W  = MAX_B + 1;
  localparam logic [SUM_W-1:0] TIME_MAX = SUM_W'((64'd1 << TIME_BITS) - 64'd1);

  // config registers
  logic [BASE_W-1:0]  base_width_r;
  logic [GAP_W-1:0]   gap_width_r;
  logic [COUNT_W-1:0] pulse_count_r;
  logic [FGAP_W-1:0]  frame_gap_r;
  logic [SYNC_W-1:0]  sync_width_r;
  logic [STEP_W-1:0]  width_step_r;

  // sequencer state
  phase_t                phase_r, phase_nxt;
  logic [TIME_BITS-1:0]  cnt_r, cnt_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic                  mode_r, mode_nxt;
  logic                  oe_r, oe_nxt;
  logic                  pend_en_r, pend_en_nxt;
  logic                  pend_sel_r, pend_sel_nxt;

  logic                  out_valid_r;
  out_item_t             out_item_r, out_item_nxt;

  logic                  accept;
  logic [INDEX_BITS-1:0] last;
  phase_t                ph_eff;
  logic [TIME_BITS-1:0]  cnt_eff;
  logic [INDEX_BITS-1:0] idx_eff;
  logic                  pe, ps;
  logic [PROD_W-1:0]     prod;
  logic [SUM_W-1:0]      data_sum;
  logic [SUM_W-1:0]      len;
  logic [SUM_W-1:0]      cnt_p1;
  logic                  done;
  logic                  halted;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign last      = INDEX_BITS'(pulse_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_width_r  <= BASE_RST;
      gap_width_r   <= GAP_RST;
      pulse_count_r <= COUNT_RST;
      frame_gap_r   <= FGAP_RST;
      sync_width_r  <= SYNC_RST;
      width_step_r  <= STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_WIDTH:  base_width_r  <= BASE_W'(cfg_data);
        REG_GAP_WIDTH:   gap_width_r   <= GAP_W'(cfg_data);
        REG_PULSE_COUNT: pulse_count_r <= COUNT_W'(cfg_data);
        REG_FRAME_GAP:   frame_gap_r   <= FGAP_W'(cfg_data);
        REG_SYNC_WIDTH:  sync_width_r  <= SYNC_W'(cfg_data);
        REG_WIDTH_STEP:  width_step_r  <= STEP_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    pe           = pend_en_r | in_item.enable_press;
    ps           = pend_sel_r | in_item.select_press;
    oe_nxt       = oe_r;
    mode_nxt     = mode_r;
    pend_en_nxt  = pe;
    pend_sel_nxt = ps;
    ph_eff       = phase_r;
    cnt_eff      = cnt_r;
    idx_eff      = idx_r;
    halted       = 1'b0;

    // latched presses take effect only at the frame boundary
    if (phase_r == PH_BOUNDARY) begin
      oe_nxt       = oe_r ^ pe;
      mode_nxt     = mode_r ^ ps;
      pend_en_nxt  = 1'b0;
      pend_sel_nxt = 1'b0;
      if (oe_nxt) begin
        ph_eff  = PH_SYNC;
        cnt_eff = '0;
        idx_eff = mode_nxt ? last : '0;
      end else begin
        halted = 1'b1;
      end
    end

    prod     = PROD_W'(idx_eff) * PROD_W'(width_step_r);
    data_sum = SUM_W'(base_width_r) + SUM_W'(prod);

    unique case (ph_eff)
      PH_SYNC: len = SUM_W'(sync_width_r);
      PH_DATA: len = (data_sum > TIME_MAX) ? TIME_MAX : data_sum;
      PH_GAP:  len = SUM_W'(gap_width_r);
      default: len = SUM_W'(frame_gap_r);
    endcase

    cnt_p1 = SUM_W'(cnt_eff) + SUM_W'(1);
    done   = (cnt_p1 >= len);

    out_item_nxt.sync_level = ~halted & (ph_eff == PH_SYNC);
    out_item_nxt.data_level = ~halted & (ph_eff == PH_DATA);
    out_item_nxt.mode_now   = mode_nxt;

    phase_nxt = ph_eff;
    idx_nxt   = idx_eff;
    cnt_nxt   = done ? '0 : TIME_BITS'(cnt_p1);

    if (halted) begin
      phase_nxt = PH_BOUNDARY;
      cnt_nxt   = cnt_r;
    end else if (done) begin
      unique case (ph_eff)
        PH_SYNC: phase_nxt = PH_DATA;
        PH_DATA: phase_nxt = PH_GAP;
        PH_GAP: begin
          if (!mode_nxt && idx_eff < last) begin
            idx_nxt   = idx_eff + INDEX_BITS'(1);
            phase_nxt = PH_DATA;
          end else if (mode_nxt && idx_eff != '0) begin
            idx_nxt   = idx_eff - INDEX_BITS'(1);
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = (frame_gap_r == '0) ? PH_BOUNDARY : PH_FGAP;
          end
        end
        default: phase_nxt = PH_BOUNDARY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_BOUNDARY;
      cnt_r      <= '0;
      idx_r      <= '0;
      mode_r     <= 1'b0;
      oe_r       <= 1'b1;
      pend_en_r  <= 1'b0;
      pend_sel_r <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      idx_r      <= idx_nxt;
      mode_r     <= mode_nxt;
      oe_r       <= oe_nxt;
      pend_en_r  <= pend_en_nxt;
      pend_sel_r <= pend_sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.sync_level && out_item.data_level))
    else $error("sync and data high together");

  a_mode_holds_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r != PH_BOUNDARY) |=> (oe_r == $past(oe_r)) && (mode_r == $past(mode_r)))
    else $error("enable or mode changed inside a frame");

  a_press_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.enable_press && phase_r != PH_BOUNDARY) |=> pend_en_r)
    else $error("enable press lost during frame");

endmodule

/* tb/tb.sv */
// Self-checking testbench for sync_and_ramp_pulse_train_generator.
// A tick-by-tick software copy of the frame sequencer predicts every result.
// Depends on sarp_pkg and the generator RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sarp_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int SAT_TICKS   = 40;
  localparam int unsigned TIME_MAX = (1 << TIME_BITS) - 1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE0 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = 3'd7;

  // {enable_press, select_press} per tick, run on a 3-tick frame
  localparam logic [1:0] DIRECTED [14] = '{
    2'b00, 2'b00, 2'b10, 2'b00, 2'b01, 2'b11, 2'b10,
    2'b10, 2'b00, 2'b11, 2'b01, 2'b00, 2'b00, 2'b00
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sync_and_ramp_pulse_train_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // shadow registers
  logic [BASE_W-1:0]  base_q;
  logic [GAP_W-1:0]   gap_q;
  logic [COUNT_W-1:0] count_q;
  logic [FGAP_W-1:0]  fgap_q;
  logic [SYNC_W-1:0]  sync_q;
  logic [STEP_W-1:0]  step_q;

  // sequencer copy
  phase_t                ph;
  logic [TIME_BITS-1:0]  tick_q;
  logic [INDEX_BITS-1:0] idx_q;
  logic                  mode_q, on_q, en_hold, sel_hold;

  in_item_t  press_q[$];
  out_item_t levels_q[$];

  int err_cnt   = 0;
  int cyc_cnt   = 0;
  int send_idle = 0;
  int stall_pct = 0;
  int hold_ask  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic void reset_model();
    base_q   = BASE_RST;
    gap_q    = GAP_RST;
    count_q  = COUNT_RST;
    fgap_q   = FGAP_RST;
    sync_q   = SYNC_RST;
    step_q   = STEP_RST;
    ph       = PH_BOUNDARY;
    tick_q   = '0;
    idx_q    = '0;
    mode_q   = 1'b0;
    on_q     = 1'b1;
    en_hold  = 1'b0;
    sel_hold = 1'b0;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_BASE_WIDTH:  base_q  = val[BASE_W-1:0];
      REG_GAP_WIDTH:   gap_q   = val[GAP_W-1:0];
      REG_PULSE_COUNT: count_q = val[COUNT_W-1:0];
      REG_FRAME_GAP:   fgap_q  = val[FGAP_W-1:0];
      REG_SYNC_WIDTH:  sync_q  = val[SYNC_W-1:0];
      REG_WIDTH_STEP:  step_q  = val[STEP_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the sequencer copy by one tick and return the pin levels of that tick.
  function automatic out_item_t next_levels(in_item_t req);
    out_item_t             lv;
    logic [INDEX_BITS-1:0] last;
    int unsigned           len;
    logic                  done;
    last = count_q[INDEX_BITS-1:0];
    if (req.enable_press) en_hold = 1'b1;
    if (req.select_press) sel_hold = 1'b1;
    if (ph == PH_BOUNDARY) begin
      if (en_hold) on_q = ~on_q;
      if (sel_hold) mode_q = ~mode_q;
      en_hold  = 1'b0;
      sel_hold = 1'b0;
      if (!on_q) begin
        lv.sync_level = 1'b0;
        lv.data_level = 1'b0;
        lv.mode_now   = mode_q;
        return lv;
      end
      ph     = PH_SYNC;
      tick_q = '0;
      idx_q  = mode_q ? last : '0;
    end
    lv.sync_level = (ph == PH_SYNC);
    lv.data_level = (ph == PH_DATA);
    lv.mode_now   = mode_q;
    case (ph)
      PH_SYNC: len = 32'(sync_q);
      PH_DATA: begin
        len = 32'(base_q) + 32'(idx_q) * 32'(step_q);
        if (len > TIME_MAX) len = TIME_MAX;
      end
      PH_GAP:  len = 32'(gap_q);
      default: len = 32'(fgap_q);
    endcase
    done   = (32'(tick_q) + 1) >= len;
    tick_q = tick_q + 1'b1;
    if (done) begin
      tick_q = '0;
      case (ph)
        PH_SYNC: ph = PH_DATA;
        PH_DATA: ph = PH_GAP;
        PH_GAP: begin
          if (!mode_q && idx_q < last) begin
            idx_q = idx_q + 1'b1;
            ph    = PH_DATA;
          end else if (mode_q && idx_q != 0) begin
            idx_q = idx_q - 1'b1;
            ph    = PH_DATA;
          end else if (fgap_q == 0) begin
            ph = PH_BOUNDARY;
          end else begin
            ph = PH_FGAP;
          end
        end
        default: ph = PH_BOUNDARY;
      endcase
    end
    return lv;
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) levels_q.push_back(next_levels(in_item));
      if (!in_valid || !in_stall) begin
        if (press_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_item  <= press_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver; a long hold-off lets the result register back up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_ask) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (levels_q.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = levels_q.pop_front();
        if (out_item.sync_level !== want.sync_level)
          report_mismatch($sformatf("sync_level got %b want %b",
                                    out_item.sync_level, want.sync_level));
        if (out_item.data_level !== want.data_level)
          report_mismatch($sformatf("data_level got %b want %b",
                                    out_item.data_level, want.data_level));
        if (out_item.mode_now !== want.mode_now)
          report_mismatch($sformatf("mode_now got %b want %b",
                                    out_item.mode_now, want.mode_now));
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_cfg(idx, val);
  endtask

  // narrow registers get junk above their width, which must be dropped
  task automatic set_cfg(int unsigned b, int unsigned g, int unsigned c,
                         int unsigned f, int unsigned s, int unsigned st);
    cfg_write(REG_BASE_WIDTH, CFG_DATA_W'(b));
    cfg_write(REG_GAP_WIDTH, CFG_DATA_W'(g));
    cfg_write(REG_PULSE_COUNT, CFG_DATA_W'(c) | CFG_DATA_W'($urandom() << COUNT_W));
    cfg_write(REG_FRAME_GAP, CFG_DATA_W'(f));
    cfg_write(REG_SYNC_WIDTH, CFG_DATA_W'(s) | CFG_DATA_W'($urandom() << SYNC_W));
    cfg_write(REG_WIDTH_STEP, CFG_DATA_W'(st) | CFG_DATA_W'($urandom() << STEP_W));
  endtask

  task automatic drain();
    while (press_q.size() != 0 || in_valid || levels_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // feed empty ticks until the next tick falls on a frame boundary
  task automatic run_to_frame_edge();
    while (ph != PH_BOUNDARY) begin
      press_q.push_back('0);
      drain();
    end
  endtask

  function automatic in_item_t rand_press(int per_mille);
    in_item_t it;
    it.enable_press = ($urandom_range(999) < per_mille);
    it.select_press = ($urandom_range(999) < per_mille);
    return it;
  endfunction

  // a press at the boundary only if output would otherwise stay off
  function automatic in_item_t wake_item();
    in_item_t it;
    it = '0;
    it.enable_press = !(on_q ^ en_hold);
    return it;
  endfunction

  task automatic queue_random(int n);
    int k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(99) < 4) begin
        repeat (4) press_q.push_back(rand_press(400));
        k += 4;
      end else begin
        press_q.push_back(rand_press(15));
        k++;
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values
    queue_random(60);
    drain();

    cfg_write(REG_SPARE0, 16'hFFFF);
    cfg_write(REG_SPARE1, 16'hFFFF);

    // zero lengths, single pulse, no frame gap
    set_cfg(0, 0, 0, 0, 0, 0);
    run_to_frame_edge();
    press_q.push_back(wake_item());
    foreach (DIRECTED[i]) press_q.push_back(in_item_t'(DIRECTED[i]));
    drain();
    set_cfg(1, 1, 1, 1, 1, 1);
    press_q.push_back(wake_item());
    repeat (8) press_q.push_back('0);
    drain();

    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin send_idle <= 23; stall_pct <= 85; end
        1: begin send_idle <= 85; stall_pct <= 23; end
        default: begin send_idle <= 0; stall_pct <= 0; end
      endcase
      for (int s = 0; s < 3; s++) begin
        if (m == 0 && s == 0)
          set_cfg(1, 0, 31, 1, 1, 0);
        else
          set_cfg($urandom_range(1, 6), $urandom_range(0, 3), $urandom_range(0, 5),
                  $urandom_range(0, 4), $urandom_range(0, 3), $urandom_range(0, 3));
        queue_random(180);
        if (m == 2 && s == 1) begin
          @(posedge clk);
          hold_ask <= hold_ask + 1;
        end
        drain();
      end
    end

    // pulse width sum above the counter range
    set_cfg(2, 1, 2, 1, 1, 1);
    run_to_frame_edge();
    set_cfg(64600, 1, 1, 0, 1023, 1000);
    press_q.push_back(wake_item());
    repeat (SAT_TICKS) press_q.push_back('0);
    drain();

    set_cfg(65535, 65535, 31, 65535, 1, 1023);
    queue_random(30);
    drain();

    repeat (5) @(posedge clk);
    if (levels_q.size() != 0) report_mismatch("results missing at end of run");
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
